// ----- rtl/biquad_shelf_filter_df2t_core_defines.svh -----
// Assertion macros for the biquad shelf filter core RTL
`ifndef BIQUAD_SHELF_FILTER_DF2T_CORE_DEFINES_SVH
`define BIQUAD_SHELF_FILTER_DF2T_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BQS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("biquad core: same-cycle check failed");

`define BQS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("biquad core: next-cycle check failed");

`else

`define BQS_ASSERT_IMP(lbl, ant, cons)

`define BQS_ASSERT_NXT(lbl, ant, cons)

`endif

`endif

// ----- rtl/bqs_pkg.sv -----
// Shared constants and types for the biquad shelf filter
`timescale 1ns / 1ps
package bqs_pkg;

  localparam int COEF_BITS          = 32;
  localparam int DELAY_BITS         = 56;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 27;
  localparam int CFG_IDX_W          = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic [DELAY_BITS-1:0] DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};

  typedef struct packed {
    logic       clear;
    logic       step;
    logic       top;
    logic [1:0] digit;
  } bqs_dctl_t;

endpackage

// ----- rtl/biquad_shelf_filter_df2t_core.sv -----
// Biquad high-shelf section, transposed direct form II, digit-serial datapath
// A sample is accepted only in idle; it then runs a radix-4 pass over the input sample digits,
//   an output step, a radix-4 pass over the output sample digits and a final update.
// A new sample is not accepted until the current one has finished its update.
// A result waiting at the output stalls only the final update cycle.
// Reset clears both delays and the output valid, sets b0 to 1.0 and the other coefficients to 0.
`timescale 1ns / 1ps
`include "biquad_shelf_filter_df2t_core_defines.svh"
module biquad_shelf_filter_df2t_core #(
  parameter int SAMPLE_BITS    = bqs_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = bqs_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
  input  logic                                s_tlast,   // end_of_block
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out
  output logic                                m_tlast,   // block_end
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bqs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bqs_pkg::COEF_BITS-1:0]       cfg_data
);
  import bqs_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DIGITS  = (SAMPLE_BITS + 1) / 2;
  localparam int XW      = 2 * DIGITS;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam int ACC_W   = XW + COEF_BITS;
  localparam int PRE_W   = (ACC_W > DELAY_BITS ? ACC_W : DELAY_BITS) + 1;
  localparam int SUM_W   = PRE_W + 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XMUL = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;
  localparam logic [2:0] S_YMUL = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [XW-1:0]    x_shift;
  logic [XW-1:0]    y_shift;
  logic [SAMPLE_BITS-1:0] y_reg;
  logic             mark;
  logic signed [DELAY_BITS-1:0] delay1;
  logic signed [DELAY_BITS-1:0] delay2;
  logic signed [PRE_W-1:0]      pre1;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic             out_last;

  logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [ACC_W-1:0]     acc_b0, acc_b1, acc_b2, acc_a1, acc_a2;

  bqs_dctl_t ctl_x;
  bqs_dctl_t ctl_y;
  logic      in_acc;
  logic      out_free;

  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] y_q;
  logic [SAMPLE_BITS-1:0]  y_sat;
  logic signed [SUM_W-1:0] d1_sum;
  logic signed [SUM_W-1:0] d2_sum;
  logic [DELAY_BITS-1:0]   d1_new;
  logic [DELAY_BITS-1:0]   d2_new;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;
  assign m_tdata   = TDATA_W'(out_sample);
  assign m_tlast   = out_last;

  always_comb begin
    ctl_x.clear = in_acc;
    ctl_x.step  = (state == S_XMUL);
    ctl_x.top   = (cnt == '0);
    ctl_x.digit = x_shift[XW-1 -: 2];
    ctl_y.clear = in_acc;
    ctl_y.step  = (state == S_YMUL);
    ctl_y.top   = (cnt == '0);
    ctl_y.digit = y_shift[XW-1 -: 2];
  end

  bqs_lane #(.ACC_W(ACC_W)) u_lane_b0 (
    .clk(clk), .ctl(ctl_x), .negate(1'b0), .coef(coef_b0), .acc(acc_b0));
  bqs_lane #(.ACC_W(ACC_W)) u_lane_b1 (
    .clk(clk), .ctl(ctl_x), .negate(1'b0), .coef(coef_b1), .acc(acc_b1));
  bqs_lane #(.ACC_W(ACC_W)) u_lane_b2 (
    .clk(clk), .ctl(ctl_x), .negate(1'b0), .coef(coef_b2), .acc(acc_b2));
  bqs_lane #(.ACC_W(ACC_W)) u_lane_a1 (
    .clk(clk), .ctl(ctl_y), .negate(1'b1), .coef(coef_a1), .acc(acc_a1));
  bqs_lane #(.ACC_W(ACC_W)) u_lane_a2 (
    .clk(clk), .ctl(ctl_y), .negate(1'b1), .coef(coef_a2), .acc(acc_a2));

  always_comb begin
    y_sum = SUM_W'(acc_b0) + SUM_W'(delay1) + ROUND;
    y_q   = y_sum >>> COEF_FRAC_BITS;
    if ((&y_q[SUM_W-1:SAMPLE_BITS-1]) | ~(|y_q[SUM_W-1:SAMPLE_BITS-1])) begin
      y_sat = y_q[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_q[SUM_W-1] ? Y_MIN : Y_MAX;
    end
  end

  always_comb begin
    d1_sum = SUM_W'(pre1) + SUM_W'(acc_a1);
    d2_sum = SUM_W'(acc_b2) + SUM_W'(acc_a2);
    if ((&d1_sum[SUM_W-1:DELAY_BITS-1]) | ~(|d1_sum[SUM_W-1:DELAY_BITS-1])) begin
      d1_new = d1_sum[DELAY_BITS-1:0];
    end else begin
      d1_new = d1_sum[SUM_W-1] ? DELAY_MIN : DELAY_MAX;
    end
    if ((&d2_sum[SUM_W-1:DELAY_BITS-1]) | ~(|d2_sum[SUM_W-1:DELAY_BITS-1])) begin
      d2_new = d2_sum[DELAY_BITS-1:0];
    end else begin
      d2_new = d2_sum[SUM_W-1] ? DELAY_MIN : DELAY_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        CFG_B0:  coef_b0 <= cfg_data;
        CFG_B1:  coef_b1 <= cfg_data;
        CFG_B2:  coef_b2 <= cfg_data;
        CFG_A1:  coef_a1 <= cfg_data;
        CFG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      delay1   <= '0;
      delay2   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_UPD) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid & m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_XMUL;
            cnt   <= '0;
          end
        end
        S_XMUL: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_YMUL;
          cnt   <= '0;
        end
        S_YMUL: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            delay1   <= d1_new;
            delay2   <= d2_new;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_shift <= XW'(signed'(s_tdata[SAMPLE_BITS-1:0]));
      mark    <= s_tlast;
    end else if (state == S_XMUL) begin
      x_shift <= x_shift << 2;
    end
    if (state == S_OUT) begin
      y_reg   <= y_sat;
      y_shift <= XW'(signed'(y_sat));
      pre1    <= PRE_W'(acc_b1) + PRE_W'(delay2);
    end else if (state == S_YMUL) begin
      y_shift <= y_shift << 2;
    end
    if ((state == S_UPD) && out_free) begin
      out_sample <= y_reg;
      out_last   <= mark;
    end
  end

  `BQS_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state == S_XMUL && cnt == '0)
  `BQS_ASSERT_NXT(a_xmul_done, state == S_XMUL && cnt == CNT_LAST, state == S_OUT)
  `BQS_ASSERT_NXT(a_upd_emits, state == S_UPD && (!m_tvalid || m_tready), m_tvalid && s_tready)
  `BQS_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !s_tready)

endmodule

// ----- rtl/bqs_lane.sv -----
// Radix-4 digit-serial multiply-accumulate lane, most significant digit first
`timescale 1ns / 1ps
module bqs_lane #(
  parameter int ACC_W = 2 * ((bqs_pkg::DEF_SAMPLE_BITS + 1) / 2) + bqs_pkg::COEF_BITS
) (
  input  logic                                clk,
  input  bqs_pkg::bqs_dctl_t                  ctl,
  input  logic                                negate,
  input  logic signed [bqs_pkg::COEF_BITS-1:0] coef,
  output logic signed [ACC_W-1:0]             acc
);
  import bqs_pkg::*;

  localparam int MAG_W = COEF_BITS + 2;

  logic signed [MAG_W-1:0] c_ext;
  logic signed [MAG_W-1:0] triple;
  logic signed [MAG_W-1:0] mag;
  logic                    sub;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    c_ext = MAG_W'(coef);
    case (ctl.digit)
      2'b00:   mag = '0;
      2'b01:   mag = c_ext;
      2'b10:   mag = c_ext <<< 1;
      2'b11:   mag = ctl.top ? c_ext : triple;
      default: mag = '0;
    endcase
    sub      = (ctl.top & ctl.digit[1]) ^ negate;
    acc_sh   = acc <<< 2;
    acc_next = sub ? acc_sh - ACC_W'(mag) : acc_sh + ACC_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc    <= '0;
      triple <= c_ext + (c_ext <<< 1);
    end else if (ctl.step) begin
      acc <= acc_next;
    end
  end

endmodule
